[hw/rtl/keyed_job_fifo_macros.svh]
// Assertion macros shared by the keyed job queue RTL.
`ifndef KEYED_JOB_FIFO_MACROS_SVH
`define KEYED_JOB_FIFO_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KJF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KJF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/kjf_pkg.sv]
// Types and constants shared by the keyed job queue modules.
package kjf_pkg;

  localparam int KEY_W    = 64;
  localparam int PAY_W    = 64;
  localparam int OFF_W    = 4;
  localparam int LEN_W    = 5;
  localparam int OP_W     = 3;
  localparam int ENTRY_W  = KEY_W + PAY_W;
  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 136;
  localparam int M_USER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_FIND   = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic enq_write;
    logic set_full;
    logic rd_head;
    logic rd_peek;
    logic scan_adv;
    logic shift_rd;
    logic shift_wr;
    logic capture;
    logic pop_head;
    logic dec_count;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic peek_ok;
    logic key_match;
    logic more;
    logic out_free;
  } ctrl_sts_t;

endpackage

[hw/rtl/keyed_job_fifo.sv]
// Keyed job queue top level: controller and datapath; one word is in flight at a time.
// Enqueue, unknown ops, and misses on an empty queue or past the end go to the result;
// dequeue and peek hits first read and capture the entry. Find scans from the front
// (position 0) until a match or the end; Remove then moves each entry behind the match
// one slot forward and drops the count. The result waits while the output is stalled.
// The next word is taken the cycle after the result loads; reset empties the queue.
module keyed_job_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [kjf_pkg::S_DATA_W-1:0] s_tdata,  // key[63:0], payload[127:64], offset[131:128]
  input  logic [kjf_pkg::OP_W-1:0]     s_tuser,  // op[2:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [kjf_pkg::M_DATA_W-1:0] m_tdata,  // out_key[63:0], out_payload[127:64],
                                                 // length[132:128]
  output logic [kjf_pkg::M_USER_W-1:0] m_tuser   // hit[0], full_res[1]
);
  import kjf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  kjf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kjf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[hw/rtl/kjf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kjf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/kjf_ctrl.sv]
// Controller state machine sequencing each queue operation.
module kjf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  kjf_pkg::ctrl_sts_t sts,
  output kjf_pkg::ctrl_cmd_t cmd
);
  import kjf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CAPT,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_RESULT;
        unique case (sts.op)
          OP_ENQ: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.enq_write = 1'b1;
            end
          end
          OP_DEQ: begin
            if (!sts.empty) begin
              cmd.rd_head = 1'b1;
              state_next  = ST_CAPT;
            end
          end
          OP_PEEK: begin
            if (sts.peek_ok) begin
              cmd.rd_peek = 1'b1;
              state_next  = ST_CAPT;
            end
          end
          OP_FIND, OP_REMOVE: begin
            if (!sts.empty) begin
              cmd.rd_head = 1'b1;
              state_next  = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_CAPT: begin
        cmd.capture  = 1'b1;
        cmd.pop_head = (sts.op == OP_DEQ);
        state_next   = ST_RESULT;
      end
      ST_SCAN: begin
        // One entry is compared per cycle while the next one is read.
        if (sts.key_match) begin
          cmd.capture = 1'b1;
          state_next  = (sts.op == OP_REMOVE) ? ST_SHIFT_RD : ST_RESULT;
        end else if (sts.more) begin
          cmd.scan_adv = 1'b1;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SHIFT_RD: begin
        if (sts.more) begin
          cmd.shift_rd = 1'b1;
          state_next   = ST_SHIFT_WR;
        end else begin
          cmd.dec_count = 1'b1;
          state_next    = ST_RESULT;
        end
      end
      ST_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SHIFT_RD;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/kjf_dp.sv]
// Datapath: circular entry store, pointers, count, item and result registers.
`include "keyed_job_fifo_macros.svh"

module kjf_dp #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [kjf_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic [kjf_pkg::OP_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kjf_pkg::M_DATA_W-1:0]    m_tdata,
  output logic [kjf_pkg::M_USER_W-1:0]    m_tuser,
  input  kjf_pkg::ctrl_cmd_t              cmd,
  output kjf_pkg::ctrl_sts_t              sts
);
  import kjf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = AW + 1;
  localparam int CMPW = (CW > OFF_W) ? CW : OFF_W;
  localparam int PADW = M_DATA_W - ENTRY_W - LEN_W;

  // Reduces a sum below twice the depth to a slot address.
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = s - SW'(DEPTH);
    return (s >= SW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  op_t            op_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;
  logic [OFF_W-1:0] off_q;

  logic [AW-1:0]  head;
  logic [CW-1:0]  count;
  logic [AW-1:0]  ptr;
  logic [CW-1:0]  idx;

  logic             res_hit;
  logic             res_full;
  logic [KEY_W-1:0] res_key;
  logic [PAY_W-1:0] res_pay;

  logic [AW-1:0]      tail;
  logic [AW-1:0]      peek_addr;
  logic [AW-1:0]      next_addr;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic               re;
  logic               we;

  assign tail      = wrap(SW'(head) + SW'(count));
  assign peek_addr = wrap(SW'(head) + SW'(off_q));
  assign next_addr = wrap(SW'(ptr) + SW'(1));

  always_comb begin
    priority if (cmd.rd_head) begin
      raddr = head;
    end else if (cmd.rd_peek) begin
      raddr = peek_addr;
    end else begin
      raddr = next_addr;
    end
  end

  assign re    = cmd.rd_head | cmd.rd_peek | cmd.scan_adv | cmd.shift_rd;
  assign we    = cmd.enq_write | cmd.shift_wr;
  assign waddr = cmd.shift_wr ? ptr : tail;
  assign wdata = cmd.shift_wr ? rdata : {pay_q, key_q};

  kjf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.op        = op_q;
  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CW'(DEPTH));
  assign sts.peek_ok   = (CMPW'(off_q) < CMPW'(count));
  assign sts.key_match = (rdata[KEY_W-1:0] == key_q);
  assign sts.more      = (CW'(idx + CW'(1)) < count);
  assign sts.out_free  = !m_tvalid || m_tready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      ptr      <= '0;
      idx      <= '0;
      res_hit  <= 1'b0;
      res_full <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.take_item) begin
        res_hit  <= 1'b0;
        res_full <= 1'b0;
      end
      if (cmd.enq_write) begin
        count   <= CW'(count + CW'(1));
        res_hit <= 1'b1;
      end
      if (cmd.set_full) begin
        res_full <= 1'b1;
      end
      if (cmd.capture) begin
        res_hit <= 1'b1;
      end
      if (cmd.rd_head) begin
        ptr <= head;
        idx <= '0;
      end
      if (cmd.scan_adv || cmd.shift_wr) begin
        ptr <= next_addr;
        idx <= CW'(idx + CW'(1));
      end
      if (cmd.pop_head) begin
        head  <= wrap(SW'(head) + SW'(1));
        count <= CW'(count - CW'(1));
      end
      if (cmd.dec_count) begin
        count <= CW'(count - CW'(1));
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item and result words.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_q    <= op_t'(s_tuser);
      key_q   <= s_tdata[KEY_W-1:0];
      pay_q   <= s_tdata[KEY_W +: PAY_W];
      off_q   <= s_tdata[ENTRY_W +: OFF_W];
      res_key <= '0;
      res_pay <= '0;
    end
    if (cmd.capture) begin
      res_key <= rdata[KEY_W-1:0];
      res_pay <= rdata[KEY_W +: PAY_W];
    end
    if (cmd.out_load) begin
      m_tdata <= {{PADW{1'b0}}, LEN_W'(count), res_pay, res_key};
      m_tuser <= {res_full, res_hit};
    end
  end

  `KJF_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `KJF_ASSERT_IMP(a_enq_room, cmd.enq_write, !sts.full, "enqueue written into a full store")
  `KJF_ASSERT_IMP(a_out_free, cmd.out_load, !m_tvalid || m_tready, "result word overwritten")
  `KJF_ASSERT_NXT(a_pop_count, cmd.pop_head, count == CW'($past(count) - CW'(1)), "pop lost count")

endmodule
